### rtl/spi_flash_command_sequencer_macros.svh
// ----------------------------------------------------------------------------
// SPI flash command sequencer assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SFCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Shared types, codes and frame byte tables.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ID   = 4'd1,
        PH_WAIT = 4'd2,
        PH_READ = 4'd3,
        PH_WREN = 4'd4,
        PH_CMD  = 4'd5,
        PH_POLL = 4'd6
    } phase_t;

    // request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_RX    = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // operations
    localparam logic [2:0] OP_IDENT   = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_PROGRAM = 3'd2;
    localparam logic [2:0] OP_ERASE   = 3'd3;
    localparam logic [2:0] OP_SIZE    = 3'd4;

    // flash commands
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] SR_BUSY   = 8'h01;

    // register indexes
    localparam logic [1:0] REG_EXPECTED_ID = 2'd0;
    localparam logic [1:0] REG_ID_RETRIES  = 2'd1;
    localparam logic [1:0] REG_PROG_TMO    = 2'd2;
    localparam logic [1:0] REG_ERASE_TMO   = 2'd3;

    localparam logic [23:0] RST_EXPECTED_ID = 24'h681015;
    localparam logic [3:0]  RST_ID_RETRIES  = 4'd5;
    localparam logic [15:0] RST_PROG_TMO    = 16'd10;
    localparam logic [15:0] RST_ERASE_TMO   = 16'd500;

    typedef struct packed {
        logic [23:0] expected_id;
        logic [3:0]  id_retries;
        logic [15:0] program_timeout_ms;
        logic [15:0] erase_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  op;
        logic [23:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        frame_last;
        logic        ok;
        logic [7:0]  rdata;
        logic [23:0] jedec_id;
        logic [7:0]  size_log2;
    } res_t;

    typedef struct packed {
        phase_t phase;
        logic   needs_erase;
    } stat_t;

    function automatic logic [2:0] frame_len(input phase_t ph, input logic [2:0] op);
        logic [2:0] len;
        begin
            unique case (ph)
                PH_ID:   len = 3'd4;
                PH_READ: len = 3'd5;
                PH_WREN: len = 3'd1;
                PH_CMD:  len = (op == OP_PROGRAM) ? 3'd5 : 3'd4;
                PH_POLL: len = 3'd2;
                default: len = 3'd1;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] frame_byte(input phase_t ph, input logic [2:0] op,
                                              input logic [2:0] k, input logic [23:0] addr,
                                              input logic [7:0] wdata);
        logic [7:0] ab;
        logic [7:0] b;
        begin
            case (k)
                3'd1:    ab = addr[23:16];
                3'd2:    ab = addr[15:8];
                3'd3:    ab = addr[7:0];
                default: ab = 8'h00;
            endcase
            unique case (ph)
                PH_ID:   b = (k == 3'd0) ? CMD_RDID : 8'h00;
                PH_READ: b = (k == 3'd0) ? CMD_READ : ab;
                PH_WREN: b = CMD_WREN;
                PH_CMD: begin
                    if (k == 3'd0) b = (op == OP_PROGRAM) ? CMD_PP : CMD_SE;
                    else if (k <= 3'd3) b = ab;
                    else b = wdata;
                end
                PH_POLL: b = (k == 3'd0) ? CMD_RDSR : 8'h00;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

### rtl/sfcs_cfg.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer configuration registers
// APB register file: expected ID, retry limit and poll timeouts.
// ----------------------------------------------------------------------------
module sfcs_cfg import sfcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_id        <= RST_EXPECTED_ID;
            cfg_reg.id_retries         <= RST_ID_RETRIES;
            cfg_reg.program_timeout_ms <= RST_PROG_TMO;
            cfg_reg.erase_timeout_ms   <= RST_ERASE_TMO;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_EXPECTED_ID: cfg_reg.expected_id        <= pwdata[23:0];
                REG_ID_RETRIES:  cfg_reg.id_retries         <= pwdata[3:0];
                REG_PROG_TMO:    cfg_reg.program_timeout_ms <= pwdata[15:0];
                REG_ERASE_TMO:   cfg_reg.erase_timeout_ms   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_EXPECTED_ID: prdata = {8'h00, cfg_reg.expected_id};
            REG_ID_RETRIES:  prdata = {28'h0, cfg_reg.id_retries};
            REG_PROG_TMO:    prdata = {16'h0, cfg_reg.program_timeout_ms};
            REG_ERASE_TMO:   prdata = {16'h0, cfg_reg.erase_timeout_ms};
            default:         prdata = 32'h0;
        endcase
    end

endmodule

### rtl/sfcs_core.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer core
// Operation state and single-pass next-state and result logic per request.
// ----------------------------------------------------------------------------
module sfcs_core import sfcs_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  res_valid,
    output res_t  res,
    output stat_t stat
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    phase_t                phase_reg, phase_next;
    logic [2:0]            cur_op_reg, cur_op_next;
    logic [2:0]            byte_index_reg, byte_index_next;
    logic [23:0]           saved_addr_reg, saved_addr_next;
    logic [7:0]            saved_wdata_reg, saved_wdata_next;
    logic [23:0]           captured_id_reg, captured_id_next;
    logic [3:0]            attempt_count_reg, attempt_count_next;
    logic [TIMER_BITS-1:0] elapsed_ms_reg, elapsed_ms_next;
    logic [23:0]           stored_id_reg, stored_id_next;
    logic                  needs_erase_reg, needs_erase_next;
    logic [7:0]            capacity_exp_reg, capacity_exp_next;

    // per-request decisions shared by the next-state and result logic
    logic                  do_next;
    logic                  do_send;
    phase_t                send_ph;
    logic                  do_done;
    logic                  done_ok;
    logic [7:0]            done_rdata;
    logic [2:0]            len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            cur_op_reg        <= '0;
            byte_index_reg    <= '0;
            saved_addr_reg    <= '0;
            saved_wdata_reg   <= '0;
            captured_id_reg   <= '0;
            attempt_count_reg <= '0;
            elapsed_ms_reg    <= '0;
            stored_id_reg     <= '0;
            needs_erase_reg   <= 1'b0;
            capacity_exp_reg  <= '0;
        end else if (step) begin
            phase_reg         <= phase_next;
            cur_op_reg        <= cur_op_next;
            byte_index_reg    <= byte_index_next;
            saved_addr_reg    <= saved_addr_next;
            saved_wdata_reg   <= saved_wdata_next;
            captured_id_reg   <= captured_id_next;
            attempt_count_reg <= attempt_count_next;
            elapsed_ms_reg    <= elapsed_ms_next;
            stored_id_reg     <= stored_id_next;
            needs_erase_reg   <= needs_erase_next;
            capacity_exp_reg  <= capacity_exp_next;
        end
    end

    assign stat.phase       = phase_reg;
    assign stat.needs_erase = needs_erase_reg;

    assign len = frame_len(phase_reg, cur_op_reg);

    // next state
    always_comb begin
        logic                  do_poll;
        logic [TIMER_BITS-1:0] poll_elapsed;
        logic [15:0]           limit;
        logic [3:0]            attempt_inc;
        logic [2:0]            idx_inc;

        phase_next         = phase_reg;
        cur_op_next        = cur_op_reg;
        byte_index_next    = byte_index_reg;
        saved_addr_next    = saved_addr_reg;
        saved_wdata_next   = saved_wdata_reg;
        captured_id_next   = captured_id_reg;
        attempt_count_next = attempt_count_reg;
        elapsed_ms_next    = elapsed_ms_reg;
        stored_id_next     = stored_id_reg;
        needs_erase_next   = needs_erase_reg;
        capacity_exp_next  = capacity_exp_reg;

        do_next      = 1'b0;
        do_send      = 1'b0;
        send_ph      = PH_IDLE;
        do_poll      = 1'b0;
        poll_elapsed = elapsed_ms_reg;
        do_done      = 1'b0;
        done_ok      = 1'b0;
        done_rdata   = 8'h00;
        attempt_inc  = attempt_count_reg + 4'd1;
        idx_inc      = byte_index_reg + 3'd1;

        unique case (item.req_type)
            REQ_START: begin
                if (phase_reg == PH_IDLE) begin
                    cur_op_next        = item.op;
                    saved_addr_next    = item.addr;
                    saved_wdata_next   = item.wdata;
                    attempt_count_next = '0;
                    unique case (item.op) inside
                        OP_IDENT, OP_SIZE:    begin do_send = 1'b1; send_ph = PH_ID;   end
                        OP_READ:              begin do_send = 1'b1; send_ph = PH_READ; end
                        OP_PROGRAM, OP_ERASE: begin do_send = 1'b1; send_ph = PH_WREN; end
                        default:              do_done = 1'b1;
                    endcase
                end
            end
            REQ_TICK: begin
                if (phase_reg == PH_POLL) begin
                    if (elapsed_ms_reg != '1)
                        elapsed_ms_next = elapsed_ms_reg + TIMER_BITS'(1);
                end else if (phase_reg == PH_WAIT) begin
                    do_send = 1'b1;
                    send_ph = PH_ID;
                end
            end
            REQ_RX: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_WAIT) begin
                    if (phase_reg == PH_ID && byte_index_reg != 3'd0)
                        captured_id_next = {captured_id_reg[15:0], item.rx_byte};
                    if ({1'b0, byte_index_reg} + 4'd1 < {1'b0, len}) begin
                        // next byte of the current frame
                        byte_index_next = idx_inc;
                        do_next         = 1'b1;
                    end else begin
                        // frame complete
                        unique case (phase_reg)
                            PH_ID: begin
                                if (cur_op_reg == OP_SIZE) begin
                                    capacity_exp_next = item.rx_byte;
                                    do_done = 1'b1;
                                    done_ok = 1'b1;
                                end else if (captured_id_next == cfg.expected_id) begin
                                    stored_id_next   = captured_id_next;
                                    needs_erase_next = 1'b1;
                                    do_done = 1'b1;
                                    done_ok = 1'b1;
                                end else begin
                                    attempt_count_next = attempt_inc;
                                    if (attempt_inc >= cfg.id_retries) do_done = 1'b1;
                                    else phase_next = PH_WAIT;
                                end
                            end
                            PH_READ: begin
                                do_done    = 1'b1;
                                done_ok    = 1'b1;
                                done_rdata = item.rx_byte;
                            end
                            PH_WREN: begin
                                do_send = 1'b1;
                                send_ph = PH_CMD;
                            end
                            PH_CMD: begin
                                elapsed_ms_next = '0;
                                poll_elapsed    = '0;
                                do_poll         = 1'b1;
                            end
                            PH_POLL: begin
                                if ((item.rx_byte & SR_BUSY) == 8'h00) begin
                                    do_done = 1'b1;
                                    done_ok = 1'b1;
                                end else begin
                                    do_poll = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        // time out before another status poll
        if (do_poll) begin
            limit = (cur_op_reg == OP_PROGRAM) ? cfg.program_timeout_ms
                                               : cfg.erase_timeout_ms;
            if (CMP_W'(poll_elapsed) >= CMP_W'(limit)) begin
                do_done = 1'b1;
            end else begin
                do_send = 1'b1;
                send_ph = PH_POLL;
            end
        end else begin
            limit = 16'h0;
        end

        if (do_send) begin
            phase_next      = send_ph;
            byte_index_next = '0;
            if (send_ph == PH_ID) captured_id_next = '0;
        end

        if (do_done) phase_next = PH_IDLE;
    end

    // result for this request
    always_comb begin
        res_valid = do_next || do_send || do_done;
        res       = '0;
        if (do_next) begin
            res.tx_byte    = frame_byte(phase_reg, cur_op_reg, byte_index_next,
                                        saved_addr_reg, saved_wdata_reg);
            res.frame_last = ({1'b0, byte_index_reg} + 4'd2 == {1'b0, len});
        end
        if (do_send) begin
            res.tx_byte    = frame_byte(send_ph, cur_op_next, 3'd0,
                                        saved_addr_next, saved_wdata_next);
            res.frame_last = (frame_len(send_ph, cur_op_next) == 3'd1);
        end
        if (do_done) begin
            res.kind      = 1'b1;
            res.ok        = done_ok;
            res.rdata     = done_rdata;
            res.jedec_id  = stored_id_next;
            res.size_log2 = capacity_exp_next;
        end
    end

endmodule

### rtl/spi_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer
// Streams SPI NOR command bytes for identify, read, program, erase and size.
// ----------------------------------------------------------------------------
// Each request on the s_ side is one start, one received SPI byte or one
// millisecond tick; it yields at most one result on the m_ side: either the
// next byte to shift out (m_tuser 0, m_tlast marks chip-select release) or
// an operation-finished report (m_tuser 1). The block takes one request per
// clock cycle sustained while m_tready keeps taking results, set by the
// single-pass decode. A request is held in an input register, is decoded
// against the sequencer state in one pass and is written to the result
// register once that register is free, from where it shows on the m_ side.
// Requests that yield no result pass the same way. While a result waits,
// the input register still takes one request and holds it; the input then
// stalls until m_tready takes the waiting result. Configuration (expected
// ID, retry count, program and erase poll timeouts, in ticks) must be
// written over APB only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer import sfcs_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[2:0], addr[26:3], wdata[34:27], rx_byte[42:35]
    input  logic [1:0]  s_tuser,   // req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // tx_byte[7:0], ok[8], rdata[16:9], jedec_id[40:17],
                                   // size_log2[48:41]
    output logic        m_tlast,   // frame_last
    output logic        m_tuser,   // kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "spi_flash_command_sequencer_macros.svh"

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg, in_valid_next;
    res_t  out_res_reg;
    logic  out_valid_reg, out_valid_next;
    logic  out_free;
    logic  advance;
    logic  core_valid;
    res_t  core_res;
    stat_t stat;

    sfcs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    // move the held request through the sequencer
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    sfcs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_valid (core_valid),
        .res       (core_res),
        .stat      (stat)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) in_valid_next = 1'b1;
        else if (advance)         in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)       out_valid_next = core_valid;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: capture request, hold result until taken
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.req_type <= s_tuser;
            in_item_reg.op       <= s_tdata[2:0];
            in_item_reg.addr     <= s_tdata[26:3];
            in_item_reg.wdata    <= s_tdata[34:27];
            in_item_reg.rx_byte  <= s_tdata[42:35];
        end
        if (advance && core_valid) out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.frame_last;
    assign m_tdata  = {7'h00, out_res_reg.size_log2, out_res_reg.jedec_id,
                       out_res_reg.rdata, out_res_reg.ok, out_res_reg.tx_byte};

    // a waiting result must never be overwritten
    `SFCS_ASSERT_NOW(a_no_overwrite, out_valid_reg && !m_tready, !advance,
        "request advanced over a stalled result")
    // a finished report always returns the sequencer to idle
    `SFCS_ASSERT_NEXT(a_done_idle, advance && core_valid && core_res.kind,
        stat.phase == PH_IDLE, "sequencer not idle after finish report")
    // an identification word is only reported once identify has matched
    `SFCS_ASSERT_NOW(a_id_flag, out_valid_reg && out_res_reg.kind && !stat.needs_erase,
        out_res_reg.jedec_id == 24'h0, "ID reported without a matching identify")

endmodule

### tb/tb_spi_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI flash command sequencer testbench
// Self-checking testbench: streams start, received-byte and tick requests,
// predicts every transmit byte and completion report, and compares them
// field by field under random valid/ready gaps and APB reconfiguration.
// ----------------------------------------------------------------------------
module tb_spi_flash_command_sequencer import sfcs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TIMER_BITS     = 16;
    localparam int unsigned TICK_MAX       = (1 << TIMER_BITS) - 1;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          DRAIN_CYCLES   = 8;    // leave slack for a request with no reply to drain
    localparam int          HOLD_CYCLES    = 600;

    // request kind the block must ignore, and the undefined operation range
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // expected reply comes from the predictor
        CHK_NONE,    // no reply may appear
        CHK_GIVEN    // expected reply is typed into the row
    } chk_t;

    typedef struct packed {
        item_t it;
        chk_t  chk;
        res_t  want;
    } row_t;

    localparam res_t NO_RES    = '0;
    localparam res_t FAIL_BARE = '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00};
    localparam res_t SENT_RDID = '{1'b0, CMD_RDID, 1'b0, 1'b0, 8'h00, 24'h000000, 8'h00};

    // Directed opener: ignored requests, undefined ops, then an identify, a size
    // detect, a read and a sector erase with extreme field values.
    localparam int N_ROWS = 30;
    localparam row_t SCRIPT [N_ROWS] = '{
        // received byte, tick and unused kind while idle: all dropped
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'hFF}, CHK_NONE,  NO_RES},
        '{'{REQ_TICK,   OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_NONE,  NO_RES},
        '{'{REQ_UNUSED, OP_UNDEF_HI, 24'hFFFFFF, 8'hFF, 8'hFF}, CHK_NONE,  NO_RES},
        // undefined operations finish at once with ok low
        '{'{REQ_START,  OP_UNDEF_HI, 24'hFFFFFF, 8'hFF, 8'h00}, CHK_GIVEN, FAIL_BARE},
        '{'{REQ_START,  OP_UNDEF_LO, 24'h000000, 8'h00, 8'h00}, CHK_GIVEN, FAIL_BARE},
        // identify with a matching answer; a start while busy is dropped
        '{'{REQ_START,  OP_IDENT,    24'h123456, 8'h5A, 8'h00}, CHK_GIVEN, SENT_RDID},
        '{'{REQ_START,  OP_READ,     24'hFFFFFF, 8'hFF, 8'h00}, CHK_NONE,  NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h68}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h10}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h15}, CHK_MODEL, NO_RES},
        // size detect keeps the last answer byte
        '{'{REQ_START,  OP_SIZE,     24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'hEF}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h40}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'hFF}, CHK_MODEL, NO_RES},
        // read at the top address
        '{'{REQ_START,  OP_READ,     24'hFFFFFF, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'hFF}, CHK_MODEL, NO_RES},
        // sector erase at address zero, flash ready on the first poll
        '{'{REQ_START,  OP_ERASE,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{'{REQ_RX,     OP_IDENT,    24'h000000, 8'h00, 8'hFE}, CHK_MODEL, NO_RES}
    };

    // ------------------------------------------------------------------------
    // DUT signals, inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // op[2:0], addr[26:3], wdata[34:27], rx_byte[42:35]
    logic [1:0]  s_tuser  = '0;    // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // tx_byte[7:0], ok[8], rdata[16:9], jedec_id[40:17],
                                   // size_log2[48:41]
    logic        m_tlast;          // frame_last
    logic        m_tuser;          // kind
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    spi_flash_command_sequencer #(.TIMER_BITS(TIMER_BITS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer predictor: own copy of the configuration and state
    // ------------------------------------------------------------------------
    cfg_t        cfg;
    phase_t      sq_phase;
    logic [2:0]  sq_op;
    logic [2:0]  sq_idx;
    logic [23:0] sq_addr;
    logic [7:0]  sq_wdata;
    logic [23:0] sq_capt;
    logic [3:0]  sq_tries;
    int unsigned sq_elapsed;
    logic [23:0] sq_id;
    bit          sq_nerase;
    logic [7:0]  sq_exp;

    res_t due [$];                 // replies the block still owes, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stage_no      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int tick_burst    = 0;
    int cycles        = 0;
    int errors        = 0;
    int n_requests    = 0;
    int n_tx          = 0;
    int n_ok          = 0;
    int n_fail        = 0;

    // byte k of the frame the sequencer is in
    function automatic logic [7:0] frame_octet(logic [2:0] k);
        logic [7:0] ab;
        ab = (k == 3'd1) ? sq_addr[23:16] :
             (k == 3'd2) ? sq_addr[15:8]  :
             (k == 3'd3) ? sq_addr[7:0]   : 8'h00;
        case (sq_phase)
            PH_ID:   return (k == 3'd0) ? CMD_RDID : 8'h00;
            PH_READ: return (k == 3'd0) ? CMD_READ : ((k <= 3'd3) ? ab : 8'h00);
            PH_WREN: return CMD_WREN;
            PH_CMD: begin
                if (k == 3'd0) return (sq_op == OP_PROGRAM) ? CMD_PP : CMD_SE;
                return (k <= 3'd3) ? ab : sq_wdata;
            end
            PH_POLL: return (k == 3'd0) ? CMD_RDSR : 8'h00;
            default: return 8'h00;
        endcase
    endfunction

    function automatic int frame_bytes();
        case (sq_phase)
            PH_ID:   return 4;
            PH_READ: return 5;
            PH_WREN: return 1;
            PH_CMD:  return (sq_op == OP_PROGRAM) ? 5 : 4;
            PH_POLL: return 2;
            default: return 1;
        endcase
    endfunction

    function automatic res_t tx_reply(logic [2:0] k);
        res_t r;
        r = '0;
        r.tx_byte    = frame_octet(k);
        r.frame_last = (int'(k) + 1 == frame_bytes());
        return r;
    endfunction

    function automatic res_t done_reply(bit ok, logic [7:0] rd);
        res_t r;
        r = '0;
        sq_phase    = PH_IDLE;
        r.kind      = 1'b1;
        r.ok        = ok;
        r.rdata     = rd;
        r.jedec_id  = sq_id;
        r.size_log2 = sq_exp;
        return r;
    endfunction

    function automatic res_t open_frame(phase_t ph);
        sq_phase = ph;
        sq_idx   = 3'd0;
        if (ph == PH_ID) sq_capt = '0;
        return tx_reply(3'd0);
    endfunction

    // give up once the poll window is used, else send another status read
    function automatic res_t poll_or_give_up();
        logic [15:0] lim;
        lim = (sq_op == OP_PROGRAM) ? cfg.program_timeout_ms : cfg.erase_timeout_ms;
        if (sq_elapsed >= lim) return done_reply(1'b0, 8'h00);
        return open_frame(PH_POLL);
    endfunction

    // advance the sequencer by one request; returns 1 when a reply is due
    function automatic bit step_sequencer(input item_t it, output res_t r);
        r = '0;
        case (it.req_type)
            REQ_START: begin
                if (sq_phase != PH_IDLE) return 1'b0;
                sq_op    = it.op;
                sq_addr  = it.addr;
                sq_wdata = it.wdata;
                sq_tries = '0;
                case (it.op) inside
                    OP_IDENT, OP_SIZE:    r = open_frame(PH_ID);
                    OP_READ:              r = open_frame(PH_READ);
                    OP_PROGRAM, OP_ERASE: r = open_frame(PH_WREN);
                    default:              r = done_reply(1'b0, 8'h00);
                endcase
                return 1'b1;
            end
            REQ_TICK: begin
                if (sq_phase == PH_POLL) begin
                    if (sq_elapsed < TICK_MAX) sq_elapsed++;
                    return 1'b0;
                end
                if (sq_phase == PH_WAIT) begin
                    r = open_frame(PH_ID);
                    return 1'b1;
                end
                return 1'b0;
            end
            REQ_RX: begin
                if (sq_phase == PH_IDLE || sq_phase == PH_WAIT) return 1'b0;
                if (sq_phase == PH_ID && sq_idx != 3'd0) sq_capt = {sq_capt[15:0], it.rx_byte};
                if (int'(sq_idx) + 1 < frame_bytes()) begin
                    sq_idx = sq_idx + 3'd1;
                    r = tx_reply(sq_idx);
                    return 1'b1;
                end
                case (sq_phase)
                    PH_ID: begin
                        if (sq_op == OP_SIZE) begin
                            sq_exp = it.rx_byte;
                            r = done_reply(1'b1, 8'h00);
                        end else if (sq_capt == cfg.expected_id) begin
                            sq_id     = sq_capt;
                            sq_nerase = 1'b1;
                            r = done_reply(1'b1, 8'h00);
                        end else begin
                            sq_tries = sq_tries + 4'd1;
                            if (sq_tries >= cfg.id_retries) begin
                                r = done_reply(1'b0, 8'h00);
                            end else begin
                                // wait for a tick before the next attempt
                                sq_phase = PH_WAIT;
                                return 1'b0;
                            end
                        end
                    end
                    PH_READ: r = done_reply(1'b1, it.rx_byte);
                    PH_WREN: r = open_frame(PH_CMD);
                    PH_CMD: begin
                        sq_elapsed = 0;
                        r = poll_or_give_up();
                    end
                    default: begin
                        // status poll: busy bit clear means done
                        if (!it.rx_byte[0]) r = done_reply(1'b1, 8'h00);
                        else r = poll_or_give_up();
                    end
                endcase
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic item_t random_request(logic [1:0] req);
        item_t it;
        it.req_type = req;
        it.op       = 3'($urandom);
        it.addr     = 24'($urandom);
        it.wdata    = 8'($urandom);
        it.rx_byte  = 8'($urandom);
        return it;
    endfunction

    // Mostly well-formed traffic that follows the predicted sequencer state,
    // with a share of arbitrary requests mixed in as noise.
    function automatic item_t choose_request();
        item_t it;
        int    pick;
        it = random_request(REQ_RX);
        if ($urandom_range(0, 99) < 8) begin
            it.req_type = 2'($urandom_range(0, 3));
            return it;
        end
        if (tick_burst > 0) begin
            tick_burst--;
            it.req_type = REQ_TICK;
            return it;
        end
        case (sq_phase)
            PH_IDLE: begin
                it.req_type = REQ_START;
                pick = $urandom_range(0, 99);
                if (pick < 20)      it.op = OP_IDENT;
                else if (pick < 38) it.op = OP_READ;
                else if (pick < 60) it.op = OP_PROGRAM;
                else if (pick < 80) it.op = OP_ERASE;
                else if (pick < 94) it.op = OP_SIZE;
                else                it.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                pick = $urandom_range(0, 9);
                if (pick == 0)      it.addr = '0;
                else if (pick == 1) it.addr = '1;
            end
            PH_WAIT: it.req_type = REQ_TICK;
            PH_POLL: begin
                // ticks come singly or in bursts so that timeouts are reached
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    tick_burst  = $urandom_range(1, 24);
                    it.req_type = REQ_TICK;
                end else if (pick < 30) begin
                    it.req_type = REQ_TICK;
                end else if (sq_idx == 3'd1) begin
                    it.rx_byte[0] = ($urandom_range(0, 99) < 60);
                end
            end
            PH_ID: begin
                // answer mostly with the accepted ID so that matches happen
                if (sq_op == OP_IDENT && sq_idx != 3'd0 && $urandom_range(0, 3) != 0)
                    it.rx_byte = 8'(cfg.expected_id >> (8 * (3 - int'(sq_idx))));
            end
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: offer one request, predict it once it is taken
    // ------------------------------------------------------------------------
    task automatic send_request(input item_t it, input chk_t chk, input res_t want);
        res_t r;
        bit   has;
        // hold valid low for a random number of cycles
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.rx_byte, it.wdata, it.addr, it.op};
        s_tuser  <= it.req_type;
        do @(posedge aclk); while (!s_tready);
        has = step_sequencer(it, r);
        if (chk == CHK_GIVEN) due.push_back(want);
        else if (chk == CHK_MODEL && has) due.push_back(r);
        n_requests++;
        @(negedge aclk);
    endtask

    // Write all four registers over APB, back to back, then drop psel.
    task automatic apply_config(input cfg_t c);
        logic [31:0] v [4];
        logic [1:0]  idx [4];
        idx = '{REG_EXPECTED_ID, REG_ID_RETRIES, REG_PROG_TMO, REG_ERASE_TMO};
        v   = '{32'(c.expected_id), 32'(c.id_retries),
                32'(c.program_timeout_ms), 32'(c.erase_timeout_ms)};
        for (int i = 0; i < 4; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[i], 2'b00};
            pwdata  <= v[i];
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            @(negedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
    endtask

    // Wait for every owed reply, then let a request with no reply drain.
    task automatic settle();
        while (due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_phase(input int id, input cfg_t c, input int quota,
                             input int s_pct, input int r_pct);
        int n;
        settle();
        apply_config(c);
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        stage_no      <= id;
        n = 0;
        // keep going past the quota until the sequencer is back to idle
        while (n < quota || sq_phase != PH_IDLE) begin
            send_request(choose_request(), CHK_MODEL, NO_RES);
            n++;
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Reply side: random ready, with one long hold-off in stage 4
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stage_no == 4 && !hold_done) begin
            // stall replies long enough for the request side to back up
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic flag_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        errors++;
    endtask

    // Compare each reply with the oldest owed one; run the cycle watchdog.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d replies owed", $realtime, due.size());
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind       = m_tuser;
            got.tx_byte    = m_tdata[7:0];
            got.frame_last = m_tlast;
            got.ok         = m_tdata[8];
            got.rdata      = m_tdata[16:9];
            got.jedec_id   = m_tdata[40:17];
            got.size_log2  = m_tdata[48:41];
            if (got.kind) begin
                if (got.ok) n_ok++;
                else n_fail++;
            end else begin
                n_tx++;
            end
            if (due.size() == 0) begin
                $display("%0t: unexpected reply, expected none, got kind %0d tx 0x%0h",
                         $realtime, got.kind, got.tx_byte);
                errors++;
            end else begin
                want = due.pop_front();
                if (got.kind !== want.kind)
                    flag_field("kind", 24'(want.kind), 24'(got.kind));
                if (got.tx_byte !== want.tx_byte)
                    flag_field("tx_byte", 24'(want.tx_byte), 24'(got.tx_byte));
                if (got.frame_last !== want.frame_last)
                    flag_field("frame_last", 24'(want.frame_last), 24'(got.frame_last));
                if (got.ok !== want.ok)
                    flag_field("ok", 24'(want.ok), 24'(got.ok));
                if (got.rdata !== want.rdata)
                    flag_field("rdata", 24'(want.rdata), 24'(got.rdata));
                if (got.jedec_id !== want.jedec_id)
                    flag_field("jedec_id", want.jedec_id, got.jedec_id);
                if (got.size_log2 !== want.size_log2)
                    flag_field("size_log2", 24'(want.size_log2), 24'(got.size_log2));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_t c;

        // predictor starts in its reset state
        cfg        = '{RST_EXPECTED_ID, RST_ID_RETRIES, RST_PROG_TMO, RST_ERASE_TMO};
        sq_phase   = PH_IDLE;
        sq_op      = '0;
        sq_idx     = '0;
        sq_addr    = '0;
        sq_wdata   = '0;
        sq_capt    = '0;
        sq_tries   = '0;
        sq_elapsed = 0;
        sq_id      = '0;
        sq_nerase  = 1'b0;
        sq_exp     = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed opener under reset configuration, sender 38 / receiver 65
        send_idle_pct = 38;
        recv_idle_pct <= 65;
        for (int i = 0; i < N_ROWS; i++)
            send_request(SCRIPT[i].it, SCRIPT[i].chk, SCRIPT[i].want);
        s_tvalid <= 1'b0;

        // low extremes, including zero retries and one-tick timeouts
        c = '{24'h000000, 4'd0, 16'd1, 16'd1};
        run_phase(1, c, 250, 38, 65);

        // high extremes: largest poll timeouts, up to fifteen ID attempts
        c = '{24'hFFFFFF, 4'd15, 16'hFFFF, 16'hFFFF};
        run_phase(2, c, 250, 65, 38);

        // random mid-range settings with short timeouts
        c.expected_id        = 24'($urandom);
        c.id_retries         = 4'($urandom_range(1, 15));
        c.program_timeout_ms = 16'($urandom_range(1, 12));
        c.erase_timeout_ms   = 16'($urandom_range(1, 40));
        run_phase(3, c, 300, 65, 38);

        // no idling, with the long reply hold-off
        c.expected_id        = 24'($urandom);
        c.id_retries         = 4'($urandom_range(1, 15));
        c.program_timeout_ms = 16'($urandom_range(1, 12));
        c.erase_timeout_ms   = 16'($urandom_range(1, 40));
        run_phase(4, c, 300, 0, 0);

        settle();
        $display("Covered %0d requests over five register settings, with a %0d-cycle reply stall",
                 n_requests, HOLD_CYCLES);
        $display("Replies seen: %0d transmit bytes, %0d operations ok, %0d operations failed",
                 n_tx, n_ok, n_fail);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### spi_flash_command_sequencer.f
+incdir+rtl
rtl/sfcs_pkg.sv
rtl/sfcs_cfg.sv
rtl/sfcs_core.sv
rtl/spi_flash_command_sequencer.sv
tb/tb_spi_flash_command_sequencer.sv
